// ===== rtl/core/gcd_pkg.sv =====
`default_nettype none
package gcd_pkg;

	// Fraction bits of the degree inputs.
	localparam int FRAC_BITS = 20;
	// Width of the clamped coordinates and their differences.
	localparam int CW = 36;
	// Width of a folded angle magnitude in degrees (at most 90 degrees; unfolded ones reach 360).
	localparam int VW = FRAC_BITS + 9;

	localparam int CORDIC_STEPS = 30;
	localparam int SQRT_STEPS = 31;

	localparam logic signed [CW-1:0] LAT_LIM = CW'(90) <<< FRAC_BITS;
	localparam logic signed [CW-1:0] LON_LIM = CW'(180) <<< FRAC_BITS;
	localparam logic [VW:0] DEG90 = (VW+1)'(90) << FRAC_BITS;
	localparam logic [VW:0] DEG180 = (VW+1)'(180) << FRAC_BITS;
	localparam logic [VW:0] DEG360 = (VW+1)'(360) << FRAC_BITS;

	localparam logic [30:0] DEG2RAD_Q36 = 31'd1199381129;
	localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [23:0] EARTH_DIAM_M = 24'd12742000;
	localparam logic [24:0] DIST_MAX = 25'd20015087;

	localparam logic signed [32:0] ATAN_Q30 [CORDIC_STEPS] = '{
		33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
		33'sd67021687, 33'sd33543516, 33'sd16775851, 33'sd8388437,
		33'sd4194283, 33'sd2097149, 33'sd1048576, 33'sd524288, 33'sd262144,
		33'sd131072, 33'sd65536, 33'sd32768, 33'sd16384, 33'sd8192,
		33'sd4096, 33'sd2048, 33'sd1024, 33'sd512, 33'sd256, 33'sd128,
		33'sd64, 33'sd32, 33'sd16, 33'sd8, 33'sd4, 33'sd2
	};

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
		logic               neg;
	} rot_t;

	typedef struct packed {
		logic [61:0] v;
		logic [61:0] r;
	} sqrt_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
	} vec_t;

endpackage
`default_nettype wire

// ===== rtl/core/gcd_rot_cell.sv =====
`default_nettype none
// One registered CORDIC rotation step; the sign of the residual angle steers it.
module gcd_rot_cell
	import gcd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic [4:0] step,
	input  wire rot_t       d_in,
	output rot_t            d_out
);

	always_ff @(posedge clk) begin
		if (d_in.z >= 0) begin
			d_out.x <= d_in.x - (d_in.y >>> step);
			d_out.y <= d_in.y + (d_in.x >>> step);
			d_out.z <= d_in.z - ATAN_Q30[step];
		end else begin
			d_out.x <= d_in.x + (d_in.y >>> step);
			d_out.y <= d_in.y - (d_in.x >>> step);
			d_out.z <= d_in.z + ATAN_Q30[step];
		end
		d_out.neg <= d_in.neg;
	end

endmodule
`default_nettype wire

// ===== rtl/core/gcd_sqrt_cell.sv =====
`default_nettype none
// One registered step of the restoring square root, one result bit per step.
module gcd_sqrt_cell
	import gcd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic [4:0] step,
	input  wire sqrt_t      d_in,
	output sqrt_t           d_out
);

	logic [61:0] bitv;
	logic [61:0] trial;

	always_comb begin
		bitv = 62'(1) << (6'd60 - {step, 1'b0});
		trial = d_in.r + bitv;
	end

	always_ff @(posedge clk) begin
		if (d_in.v >= trial) begin
			d_out.v <= d_in.v - trial;
			d_out.r <= (d_in.r >> 1) + bitv;
		end else begin
			d_out.v <= d_in.v;
			d_out.r <= d_in.r >> 1;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/gcd_vec_cell.sv =====
`default_nettype none
// One registered CORDIC vectoring step; the sign of y steers it.
module gcd_vec_cell
	import gcd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic [4:0] step,
	input  wire vec_t       d_in,
	output vec_t            d_out
);

	always_ff @(posedge clk) begin
		if (d_in.y < 0) begin
			d_out.x <= d_in.x - (d_in.y >>> step);
			d_out.y <= d_in.y + (d_in.x >>> step);
			d_out.z <= d_in.z - ATAN_Q30[step];
		end else begin
			d_out.x <= d_in.x + (d_in.y >>> step);
			d_out.y <= d_in.y - (d_in.x >>> step);
			d_out.z <= d_in.z + ATAN_Q30[step];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/great_circle_distance_top.sv =====
`default_nettype none
// Throughput: one transaction per cycle; busy is never raised, because every
// stage is a register cell and the receiver cannot stall the result.
// Reset: arst_n clears the valid chain asynchronously; data registers are
// not reset and hold nothing of meaning until a transaction has passed.
module great_circle_distance_top
	import gcd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [27:0] lat_a,
	input  wire logic signed [28:0] lon_a,
	input  wire logic signed [27:0] lat_b,
	input  wire logic signed [28:0] lon_b,
	output logic                    done,
	output logic [24:0]             distance_m
);

	// Four clamp/fold/scale stages, the rotation chain, three stages that
	// build the haversine term, the square-root chain, the vectoring chain,
	// then the scale to metres and the saturation.
	localparam int LAT = 4 + CORDIC_STEPS + 3 + SQRT_STEPS + CORDIC_STEPS + 2;
	// Lanes of the rotation chain: lat_a, lat_b, latitude and longitude deltas.
	localparam int LANES = 4;

	logic [LAT-1:0] vld_q;

	logic signed [CW-1:0] lat1_s1, lat2_s1, lon1_s1, lon2_s1;
	logic [VW:0]          mag_s2 [LANES];
	logic [VW-1:0]        fold_s3 [LANES];
	logic                 neg_s3 [LANES];
	rot_t                 rot_s4 [LANES];
	rot_t                 rot_c [LANES][CORDIC_STEPS+1];
	logic signed [31:0]   cos_s35 [LANES];
	logic signed [32:0]   hlat_s36, hlon_s36;
	logic signed [31:0]   cc_s36;
	logic [30:0]          a_s37;
	sqrt_t                sq_s [SQRT_STEPS+1];
	sqrt_t                sq_t [SQRT_STEPS+1];
	vec_t                 vec_c [CORDIC_STEPS+1];
	logic [24:0]          d_s99;

	assign busy = 1'b0;

	// The strobe is simply the end of the valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end
	assign done = vld_q[LAT-1];

	// Stage 1: out-of-range coordinates saturate to the poles and the date line.
	function automatic logic signed [CW-1:0] clamp_c(input logic signed [CW-1:0] v,
			input logic signed [CW-1:0] lim);
		logic signed [CW-1:0] r;
		begin
			r = v;
			if (v > lim) r = lim;
			if (v < -lim) r = -lim;
			return r;
		end
	endfunction

	always_ff @(posedge clk) begin
		lat1_s1 <= clamp_c(CW'(lat_a), LAT_LIM);
		lon1_s1 <= clamp_c(CW'(lon_a), LON_LIM);
		lat2_s1 <= clamp_c(CW'(lat_b), LAT_LIM);
		lon2_s1 <= clamp_c(CW'(lon_b), LON_LIM);
	end

	// Stage 2: magnitudes of the four angles whose cosines are needed.
	logic signed [CW-1:0] ang_c [LANES];
	always_comb begin
		ang_c[0] = lat1_s1;
		ang_c[1] = lat2_s1;
		ang_c[2] = lat1_s1 - lat2_s1;
		ang_c[3] = lon1_s1 - lon2_s1;
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			mag_s2[l] <= (ang_c[l] < 0) ? (VW+1)'(-ang_c[l]) : (VW+1)'(ang_c[l]);
		end
	end

	// Stage 3: fold into the first quadrant; the second quadrant flips the sign.
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			logic [VW:0] v;
			v = mag_s2[l];
			if (v > DEG180) v = DEG360 - v;
			if (v > DEG90) begin
				fold_s3[l] <= VW'(DEG180 - v);
				neg_s3[l] <= 1'b1;
			end else begin
				fold_s3[l] <= VW'(v);
				neg_s3[l] <= 1'b0;
			end
		end
	end

	// Stage 4: degrees to Q30 radians, seeding the rotation chain.
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			logic [VW+30:0] p;
			p = (VW+31)'(fold_s3[l]) * (VW+31)'(DEG2RAD_Q36);
			rot_s4[l].x <= GAIN_INV;
			rot_s4[l].y <= '0;
			rot_s4[l].z <= 33'(p >> (FRAC_BITS + 6));
			rot_s4[l].neg <= neg_s3[l];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		assign rot_c[l][0] = rot_s4[l];
		for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
			gcd_rot_cell u_rot (
				.clk  (clk),
				.step (5'(i)),
				.d_in (rot_c[l][i]),
				.d_out(rot_c[l][i+1])
			);
		end
	end

	// Stage 35: each cosine is clamped to [0, 1] before its sign goes on.
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			logic signed [33:0] x;
			logic signed [31:0] c;
			x = rot_c[l][CORDIC_STEPS].x;
			if (x < 0) c = '0;
			else if (x > 34'(Q30_ONE)) c = 32'(Q30_ONE);
			else c = 32'(x);
			cos_s35[l] <= rot_c[l][CORDIC_STEPS].neg ? -c : c;
		end
	end

	// Stage 36: half-versines and the product of the latitude cosines.
	logic signed [63:0] ccp_c;
	assign ccp_c = 64'(cos_s35[0]) * 64'(cos_s35[1]);

	always_ff @(posedge clk) begin
		hlat_s36 <= (33'(Q30_ONE) - 33'(cos_s35[2])) >>> 1;
		hlon_s36 <= (33'(Q30_ONE) - 33'(cos_s35[3])) >>> 1;
		cc_s36 <= 32'(ccp_c >>> 30);
	end

	// Stage 37: the haversine term a, clamped to [0, 1].
	logic signed [64:0] hp_c;
	logic signed [35:0] asum_c;
	assign hp_c = 65'(cc_s36) * 65'(hlon_s36);
	assign asum_c = 36'(hlat_s36) + 36'(hp_c >>> 30);

	always_ff @(posedge clk) begin
		if (asum_c < 0) a_s37 <= '0;
		else if (asum_c > 36'(Q30_ONE)) a_s37 <= Q30_ONE;
		else a_s37 <= 31'(asum_c);
	end

	// Square roots of a and 1 - a, both Q30 after the shift by 30.
	assign sq_s[0].v = 62'(a_s37) << 30;
	assign sq_s[0].r = '0;
	assign sq_t[0].v = 62'(Q30_ONE - a_s37) << 30;
	assign sq_t[0].r = '0;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		gcd_sqrt_cell u_sq_s (
			.clk  (clk),
			.step (5'(i)),
			.d_in (sq_s[i]),
			.d_out(sq_s[i+1])
		);
		gcd_sqrt_cell u_sq_t (
			.clk  (clk),
			.step (5'(i)),
			.d_in (sq_t[i]),
			.d_out(sq_t[i+1])
		);
	end

	// Half the central angle is atan2(sqrt(a), sqrt(1 - a)).
	assign vec_c[0].x = 34'(sq_t[SQRT_STEPS].r[30:0]);
	assign vec_c[0].y = 34'(sq_s[SQRT_STEPS].r[30:0]);
	assign vec_c[0].z = '0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		gcd_vec_cell u_vec (
			.clk  (clk),
			.step (5'(i)),
			.d_in (vec_c[i]),
			.d_out(vec_c[i+1])
		);
	end

	// Stage 99: a slightly negative angle from rounding counts as zero;
	// scale by the diameter, since the angle is half the central angle.
	logic [30:0] ang_c2;
	logic [54:0] dp_c;
	assign ang_c2 = (vec_c[CORDIC_STEPS].z < 0) ? '0 : vec_c[CORDIC_STEPS].z[30:0];
	assign dp_c = 55'(ang_c2) * 55'(EARTH_DIAM_M);

	always_ff @(posedge clk) begin
		d_s99 <= dp_c[54:30];
	end

	// Stage 100: saturate at half the circumference.
	always_ff @(posedge clk) begin
		distance_m <= (d_s99 > DIST_MAX) ? DIST_MAX : d_s99;
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a transaction");

	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> distance_m <= DIST_MAX)
		else $error("distance beyond half circumference");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
// Self-checking bench for the great-circle distance pipeline.
// A driver takes point pairs from a queue and presents them at falling edges;
// a monitor samples done at rising edges and checks each distance against a
// predictor of the fixed-point haversine computation.
module tb_top
	import gcd_pkg::*;
;

	typedef struct {
		logic signed [27:0] lat_a;
		logic signed [28:0] lon_a;
		logic signed [27:0] lat_b;
		logic signed [28:0] lon_b;
	} pair_t;

	localparam longint CYCLE_LIMIT = 400000;
	localparam int PIPE_DRAIN = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	logic signed [27:0] lat_a = '0;
	logic signed [28:0] lon_a = '0;
	logic signed [27:0] lat_b = '0;
	logic signed [28:0] lon_b = '0;
	logic [24:0] distance_m;

	pair_t pending_pairs[$];
	logic [24:0] expected_dist[$];
	int idle_pct = 0;
	bit hold_off = 1'b0;
	int errors = 0;
	int checked = 0;
	longint cycles = 0;

	great_circle_distance_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.done(done), .distance_m(distance_m)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Floor division by a power of two, written out so that the sign is explicit.
	function automatic longint floor_shr(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Cosine of an angle in fixed-point degrees, result Q30, via CORDIC rotation.
	function automatic longint cos_q30(longint deg);
		longint one_deg;
		longint v;
		longint z;
		longint x;
		longint y;
		longint nx;
		bit neg;
		one_deg = longint'(1) << FRAC_BITS;
		v = deg < 0 ? -deg : deg;
		neg = 1'b0;
		if (v > 180 * one_deg)
			v = 360 * one_deg - v;
		if (v > 90 * one_deg) begin
			v = 180 * one_deg - v;
			neg = 1'b1;
		end
		z = (v * longint'(DEG2RAD_Q36)) >>> (FRAC_BITS + 6);
		x = longint'(GAIN_INV);
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z -= longint'(ATAN_Q30[i]);
			end else begin
				nx = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z += longint'(ATAN_Q30[i]);
			end
			x = nx;
		end
		x = clip(x, 0, longint'(1) << 30);
		return neg ? -x : x;
	endfunction

	function automatic longint root_floor(longint v);
		longint r;
		longint b;
		r = 0;
		b = longint'(1) << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [24:0] haversine_m(pair_t p);
		longint one_deg;
		longint la1;
		longint lo1;
		longint la2;
		longint lo2;
		longint h_lat;
		longint h_lon;
		longint cc;
		longint hav;
		longint s;
		longint c;
		longint x;
		longint y;
		longint z;
		longint nx;
		longint d;
		one_deg = longint'(1) << FRAC_BITS;
		la1 = clip(longint'(p.lat_a), -90 * one_deg, 90 * one_deg);
		lo1 = clip(longint'(p.lon_a), -180 * one_deg, 180 * one_deg);
		la2 = clip(longint'(p.lat_b), -90 * one_deg, 90 * one_deg);
		lo2 = clip(longint'(p.lon_b), -180 * one_deg, 180 * one_deg);
		h_lat = floor_shr((longint'(1) << 30) - cos_q30(la1 - la2), 1);
		h_lon = floor_shr((longint'(1) << 30) - cos_q30(lo1 - lo2), 1);
		cc = floor_shr(cos_q30(la1) * cos_q30(la2), 30);
		hav = clip(h_lat + floor_shr(cc * h_lon, 30), 0, longint'(1) << 30);
		s = root_floor(hav << 30);
		c = root_floor(((longint'(1) << 30) - hav) << 30);
		// Vectoring CORDIC for the central angle.
		x = c;
		y = s;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y < 0) begin
				nx = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z -= longint'(ATAN_Q30[i]);
			end else begin
				nx = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z += longint'(ATAN_Q30[i]);
			end
			x = nx;
		end
		// A slightly negative angle from rounding counts as zero.
		if (z < 0)
			z = 0;
		d = (z * longint'(EARTH_DIAM_M)) >>> 30;
		if (d > longint'(DIST_MAX))
			d = longint'(DIST_MAX);
		return d[24:0];
	endfunction

	// Driver: a transaction is accepted at the rising edge where start is high
	// and busy is low, so inputs change only at falling edges.
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				// The previous transaction went in at the last rising edge.
			end
			if (!(start && busy)) begin
				if (!hold_off && pending_pairs.size() != 0 &&
						$urandom_range(99, 0) >= idle_pct) begin
					pair_t p;
					p = pending_pairs.pop_front();
					lat_a <= p.lat_a;
					lon_a <= p.lon_a;
					lat_b <= p.lat_b;
					lon_b <= p.lon_b;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
					lat_a <= 28'($urandom);
					lon_b <= 29'($urandom);
				end
			end
		end
	end

	// The expectation is recorded at the edge that accepts the transaction, so
	// that it is always queued well before its result can come back.
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (start && !busy) begin
				pair_t p;
				p.lat_a = lat_a;
				p.lon_a = lon_a;
				p.lat_b = lat_b;
				p.lon_b = lon_b;
				expected_dist.insert(expected_dist.size(), haversine_m(p));
			end
			if (done) begin
				if (expected_dist.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d",
						$time, distance_m);
					errors <= errors + 1;
				end else begin
					logic [24:0] want;
					want = expected_dist.pop_front();
					checked <= checked + 1;
					if (want !== distance_m) begin
						$display("%0t: distance_m mismatch, expected %0d, actual %0d",
							$time, want, distance_m);
						errors <= errors + 1;
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t: timeout with %0d results outstanding", $time,
					expected_dist.size());
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	function automatic logic signed [27:0] rand_lat();
		int unsigned k;
		k = $urandom_range(19, 0);
		if (k == 0)
			return 28'($urandom);
		if (k == 1)
			return $urandom_range(1, 0) ? LAT_LIM[27:0] : -LAT_LIM[27:0];
		return 28'(int'($urandom_range(2 * 94371840, 0)) - 94371840);
	endfunction

	function automatic logic signed [28:0] rand_lon();
		int unsigned k;
		k = $urandom_range(19, 0);
		if (k == 0)
			return 29'($urandom);
		if (k == 1)
			return $urandom_range(1, 0) ? LON_LIM[28:0] : -LON_LIM[28:0];
		return 29'(int'($urandom_range(2 * 188743680, 0)) - 188743680);
	endfunction

	task automatic add_pair(longint la1, longint lo1, longint la2, longint lo2);
		pair_t p;
		p.lat_a = 28'(la1);
		p.lon_a = 29'(lo1);
		p.lat_b = 28'(la2);
		p.lon_b = 29'(lo2);
		pending_pairs.insert(pending_pairs.size(), p);
	endtask

	task automatic wait_drained();
		while (pending_pairs.size() != 0 || start)
			@(posedge clk);
		while (expected_dist.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		longint u;
		pair_t p;
		u = longint'(1) << FRAC_BITS;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: identical points, poles, antipodes, the date line, and
		// coordinates past the bounds, which must saturate.
		add_pair(0, 0, 0, 0);
		add_pair(90 * u, 0, -90 * u, 0);
		add_pair(0, 0, 0, 180 * u);
		add_pair(0, -180 * u, 0, 180 * u);
		add_pair(0, 179 * u, 0, -179 * u);
		add_pair(90 * u, 0, 90 * u, 123 * u);
		add_pair(45 * u, 10 * u, 45 * u + 1, 10 * u);
		add_pair(0, 0, 0, 1);
		add_pair(28'sh7ff_ffff, 29'sh0fff_ffff, -28'sh800_0000, -29'sh1000_0000);
		add_pair(-28'sh800_0000, -29'sh1000_0000, 28'sh7ff_ffff, 29'sh0fff_ffff);
		add_pair(100 * u, 200 * u, -100 * u, -200 * u);
		add_pair(-1, -1, 1, 1);
		add_pair(30 * u, 90 * u, -30 * u, -90 * u);
		add_pair(60 * u, 0, -60 * u, 180 * u);
		add_pair(-45 * u, 135 * u, 45 * u, -45 * u);
		add_pair(89 * u, 0, -89 * u, 180 * u);
		wait_drained();

		// Random phases at differing sender gaps; the receiver cannot stall.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 63 : (ph == 3 ? 7 : 0);
			for (int n = 0; n < 400; n++) begin
				if ($urandom_range(9, 0) == 0) begin
					// Near neighbours and pairs half a turn of longitude apart stress the rounding ends.
					p.lat_a = rand_lat();
					p.lon_a = rand_lon();
					p.lat_b = p.lat_a + 28'(int'($urandom_range(64, 0)) - 32);
					p.lon_b = $urandom_range(1, 0) ? p.lon_a + 29'($urandom_range(8, 0))
						: p.lon_a + 29'(180 * u);
				end else begin
					p.lat_a = rand_lat();
					p.lon_a = rand_lon();
					p.lat_b = rand_lat();
					p.lon_b = rand_lon();
				end
				pending_pairs.insert(pending_pairs.size(), p);
				if (n == 200) begin
					// Pause the sender until the pipeline has emptied.
					while (pending_pairs.size() != 0)
						@(posedge clk);
					hold_off = 1'b1;
					while (expected_dist.size() != 0)
						@(posedge clk);
					hold_off = 1'b0;
				end
			end
			wait_drained();
		end

		repeat (PIPE_DRAIN) @(posedge clk);
		$display("Covered %0d distance checks over poles, antipodes, saturating inputs",
			checked);
		$display("and random point pairs at several sender idling rates.");
		if (errors == 0 && expected_dist.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire
